### design/fzrs_pkg.sv
`default_nettype none

package fzrs_pkg;

   localparam int ZONES_DEFAULT = 4;
   localparam int DIVIDEND_W    = 33;
   localparam int DIVISOR_W     = 21;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   localparam logic [2:0] OPC_READ    = 3'd0;
   localparam logic [2:0] OPC_PROGRAM = 3'd1;
   localparam logic [2:0] OPC_ERASE   = 3'd2;
   localparam logic [2:0] OPC_STOP    = 3'd3;
   localparam logic [2:0] OPC_TICK    = 3'd4;

   localparam logic [3:0] ST_SUCCESS     = 4'd0;
   localparam logic [3:0] ST_IN_PROGRESS = 4'd1;
   localparam logic [3:0] ST_BUSY        = 4'd2;
   localparam logic [3:0] ST_STOPPED     = 4'd3;
   localparam logic [3:0] ST_INVALID     = 4'd4;
   localparam logic [3:0] ST_PERMISSION  = 4'd5;
   localparam logic [3:0] ST_RANGE       = 4'd6;
   localparam logic [3:0] ST_CONFIG      = 4'd7;
   localparam logic [3:0] ST_DRIVER      = 4'd8;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_WAIT    = 3'd4;
   localparam logic [2:0] PH_STOPPED = 3'd5;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_PROGRAM = 2'd2;
   localparam logic [1:0] ACT_ERASE   = 2'd3;

   localparam logic [1:0] KIND_SYNC = 2'd3;

   localparam logic [1:0] DEV_READY = 2'd0;
   localparam logic [1:0] DEV_BUSY  = 2'd1;

   localparam logic [2:0] REG_PAGE_SIZE   = 3'd0;
   localparam logic [2:0] REG_BLOCK_SIZE  = 3'd1;
   localparam logic [2:0] REG_MAX_READ    = 3'd2;
   localparam logic [2:0] REG_SYNC        = 3'd3;
   localparam logic [2:0] REG_PERMISSIONS = 3'd4;
   localparam logic [2:0] REG_ZONE_BLOCKS = 3'd5;

   localparam logic [16:0] PAGE_SIZE_RESET  = 17'd256;
   localparam logic [20:0] BLOCK_SIZE_RESET = 21'd4096;

   typedef enum logic [1:0] {
      DIV_OFF,
      DIV_END,
      DIV_PG
   } div_sel_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [1:0]  zone;
      logic [31:0] offset;
      logic [31:0] length;
      logic [1:0]  device_status;
      logic        device_accept;
   } req_type;

   typedef struct packed {
      logic [3:0]  request_status;
      logic        cmd_valid;
      logic [1:0]  cmd_kind;
      logic [31:0] cmd_address;
      logic [31:0] cmd_length;
      logic [31:0] cmd_buffer_offset;
      logic [2:0]  engine_state;
      logic [3:0]  last_result;
      logic        busy_res;
   } rsp_type;

   typedef struct packed {
      logic        capture;
      logic        loop_init;
      logic        mul;
      logic        acc;
      logic        div_start;
      div_sel_type div_sel;
      logic        save_off_rem;
      logic        commit;
   } fzrs_cmd_type;

   typedef struct packed {
      logic req_go;
      logic need_pg_div;
      logic k_eq_z;
      logic need_erase_div;
      logic div_busy;
   } fzrs_sts_type;

endpackage

`default_nettype wire

### design/flash_zone_request_sequencer_unit.sv
// Channel   Ports                              Moves
// req       req_valid/req_ready/req_data       one request (req_type)
// rsp       rsp_valid/rsp_ready/rsp_data       one result (rsp_type)
// csr       csr_write_en/csr_index/csr_data    register write, no wait
//
// A tick that issues a program chunk waits on the 33-step address remainder.
// A read/program request runs decode, a multiply/accumulate per zone up to its
// own, check and commit; an erase adds two 33-step remainders in the shared divider.
// Reset is synchronous and clears engine state and registers to defaults.
// A new request is taken while the previous result waits in the output
// register; the commit step holds until that result is taken.
`default_nettype none

module flash_zone_request_sequencer_unit
   import fzrs_pkg::*;
#(
   parameter int ZONES = ZONES_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   fzrs_cmd_type cmd;
   fzrs_sts_type sts;

   fzrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fzrs_dp #(
      .ZONES (ZONES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

### design/fzrs_div.sv
`default_nettype none

module fzrs_div
   import fzrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      count_ff;
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_sub;

   assign rem_sh  = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_W'(DIVIDEND_W);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (count_ff != '0) begin
         dvd_ff <= {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_ff <= rem_sub[DIVISOR_W-1:0];
         end else begin
            rem_ff <= rem_sh[DIVISOR_W-1:0];
         end
      end
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### design/fzrs_dp.sv
`default_nettype none

module fzrs_dp
   import fzrs_pkg::*;
#(
   parameter int ZONES = ZONES_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire req_type                req_data,
   input  wire fzrs_cmd_type           cmd,
   output fzrs_sts_type                sts,
   output rsp_type                     rsp_data
);

   logic [16:0] page_size_ff;
   logic [20:0] block_size_ff;
   logic [16:0] max_read_ff;
   logic        sync_present_ff;
   logic [11:0] perm_ff;
   logic [63:0] zone_blocks_ff;

   req_type     req_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  act_ff, act_in;
   logic [31:0] phys_ff, phys_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] pend_ff, pend_in;
   logic [31:0] done_ff, done_in;
   logic        sync_sent_ff, sync_sent_in;
   logic        stop_ff, stop_in;
   logic [3:0]  result_ff, result_in;
   rsp_type     rsp_ff, rsp_in;

   logic [1:0]  k_ff;
   logic [38:0] base_ff;
   logic [36:0] size_ff;
   logic [36:0] prod_ff;
   logic [20:0] off_rem_ff;

   logic [20:0] blk_eff;
   logic [16:0] pg_eff;
   logic [15:0] zcnt_sel;
   logic [36:0] prod_in;

   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_busy;
   logic [DIVISOR_W-1:0]  div_rem;

   logic        is_request;
   logic        zone_ok;
   logic [3:0]  perm_idx;
   logic        perm_ok;
   logic        range_early;
   logic        len_zero;
   logic        is_erase;
   logic [32:0] end_sum;
   logic [31:0] start_e;
   logic [33:0] end_up;
   logic [33:0] end_sel;
   logic [33:0] span_e;
   logic [31:0] start_sel;
   logic [31:0] span_sel;
   logic [39:0] total;
   logic        range_late;
   logic [38:0] phys_sum;
   logic [31:0] dec;
   logic [31:0] rem_after;
   logic [16:0] avail;
   logic [31:0] chunk;

   assign blk_eff  = (block_size_ff == '0) ? 21'd1 : block_size_ff;
   assign pg_eff   = (page_size_ff == '0) ? 17'd1 : page_size_ff;
   assign zcnt_sel = zone_blocks_ff[{k_ff, 4'b0000} +: 16];
   assign prod_in  = 37'(zcnt_sel) * 37'(blk_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff    <= PAGE_SIZE_RESET;
         block_size_ff   <= BLOCK_SIZE_RESET;
         max_read_ff     <= '0;
         sync_present_ff <= 1'b0;
         perm_ff         <= '0;
         zone_blocks_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_PAGE_SIZE:   page_size_ff    <= csr_data[16:0];
            REG_BLOCK_SIZE:  block_size_ff   <= csr_data[20:0];
            REG_MAX_READ:    max_read_ff     <= csr_data[16:0];
            REG_SYNC:        sync_present_ff <= csr_data[0];
            REG_PERMISSIONS: perm_ff         <= csr_data[11:0];
            REG_ZONE_BLOCKS: zone_blocks_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_OFF: div_dividend = {1'b0, req_ff.offset};
         DIV_END: div_dividend = end_sum;
         default: div_dividend = {1'b0, phys_ff};
      endcase
      if (cmd.div_sel == DIV_PG) begin
         div_divisor = {4'b0000, pg_eff};
      end else begin
         div_divisor = blk_eff;
      end
   end

   fzrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.loop_init) begin
         k_ff    <= '0;
         base_ff <= '0;
      end else if (cmd.acc) begin
         if (k_ff == req_ff.zone) begin
            size_ff <= prod_ff;
         end else begin
            base_ff <= base_ff + 39'(prod_ff);
            k_ff    <= k_ff + 2'd1;
         end
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.save_off_rem) begin
         off_rem_ff <= div_rem;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign is_request  = (req_ff.opcode == OPC_READ) || (req_ff.opcode == OPC_PROGRAM) ||
                        (req_ff.opcode == OPC_ERASE);
   assign is_erase    = (req_ff.opcode == OPC_ERASE);
   assign zone_ok     = ({1'b0, req_ff.zone} < 3'(ZONES));
   assign perm_idx    = ({2'b00, req_ff.zone} * 4'd3) + {1'b0, req_ff.opcode};
   assign perm_ok     = is_request && perm_ff[perm_idx];
   assign range_early = ({5'b0, req_ff.offset} > size_ff) ||
                        ({5'b0, req_ff.length} > (size_ff - {5'b0, req_ff.offset}));
   assign len_zero    = (req_ff.length == '0);

   assign end_sum   = {1'b0, req_ff.offset} + {1'b0, req_ff.length};
   assign start_e   = req_ff.offset - {11'b0, off_rem_ff};
   assign end_up    = (div_rem != '0) ?
                      ({1'b0, end_sum} + 34'(blk_eff) - 34'(div_rem)) : {1'b0, end_sum};
   assign end_sel   = is_erase ? end_up : {1'b0, end_sum};
   assign span_e    = end_up - 34'(start_e);
   assign start_sel = is_erase ? start_e : req_ff.offset;
   assign span_sel  = is_erase ? span_e[31:0] : req_ff.length;
   assign total     = 40'(base_ff) + 40'(end_sel);
   assign range_late = (is_erase && (37'(end_up) > size_ff)) ||
                       (total > 40'h01_0000_0000);
   assign phys_sum  = base_ff + 39'(start_sel);

   assign dec       = (pend_ff > rem_ff) ? rem_ff : pend_ff;
   assign rem_after = rem_ff - dec;
   assign avail     = pg_eff - div_rem[16:0];

   always_comb begin
      case (act_ff)
         ACT_READ: begin
            if ((max_read_ff != '0) && (rem_ff > 32'(max_read_ff))) begin
               chunk = 32'(max_read_ff);
            end else begin
               chunk = rem_ff;
            end
         end
         ACT_PROGRAM: chunk = (rem_ff < 32'(avail)) ? rem_ff : 32'(avail);
         default:     chunk = 32'(blk_eff);
      endcase
   end

   always_comb begin
      logic       do_end;
      logic [3:0] end_code;
      logic [3:0] status;
      phase_in     = phase_ff;
      act_in       = act_ff;
      phys_in      = phys_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      done_in      = done_ff;
      sync_sent_in = sync_sent_ff;
      stop_in      = stop_ff;
      result_in    = result_ff;
      do_end       = 1'b0;
      end_code     = ST_SUCCESS;
      status       = ST_SUCCESS;
      rsp_in       = '0;
      case (req_ff.opcode)
         OPC_READ, OPC_PROGRAM, OPC_ERASE: begin
            if (phase_ff == PH_STOPPED) begin
               status = ST_STOPPED;
            end else if (act_ff != ACT_NONE) begin
               status = ST_BUSY;
            end else if (!zone_ok) begin
               status = ST_INVALID;
            end else if (!perm_ok) begin
               status = ST_PERMISSION;
            end else if (range_early) begin
               status = ST_RANGE;
            end else if (len_zero) begin
               status    = ST_SUCCESS;
               result_in = ST_SUCCESS;
            end else if (range_late) begin
               status = ST_RANGE;
            end else begin
               phys_in      = phys_sum[31:0];
               rem_in       = span_sel;
               pend_in      = '0;
               done_in      = '0;
               sync_sent_in = 1'b0;
               act_in       = req_ff.opcode[1:0] + 2'd1;
               phase_in     = {1'b0, req_ff.opcode[1:0] + 2'd1};
               result_in    = ST_IN_PROGRESS;
               status       = ST_IN_PROGRESS;
            end
         end
         OPC_STOP: begin
            stop_in = 1'b1;
            if (act_ff == ACT_NONE) begin
               phase_in = PH_STOPPED;
            end
            status = ST_SUCCESS;
         end
         OPC_TICK: begin
            if (act_ff != ACT_NONE) begin
               if (req_ff.device_status[1]) begin
                  do_end   = 1'b1;
                  end_code = ST_DRIVER;
               end else if (phase_ff == PH_WAIT) begin
                  if (req_ff.device_status != DEV_BUSY) begin
                     if (pend_ff != '0) begin
                        phys_in = phys_ff + pend_ff;
                        rem_in  = rem_after;
                        if (act_ff != ACT_ERASE) begin
                           done_in = done_ff + pend_ff;
                        end
                        pend_in = '0;
                        if (rem_after == '0) begin
                           if (sync_present_ff && !sync_sent_ff) begin
                              rsp_in.cmd_valid = 1'b1;
                              rsp_in.cmd_kind  = KIND_SYNC;
                              if (!req_ff.device_accept) begin
                                 do_end   = 1'b1;
                                 end_code = ST_DRIVER;
                              end else begin
                                 sync_sent_in = 1'b1;
                                 phase_in     = PH_WAIT;
                              end
                           end else begin
                              do_end   = 1'b1;
                              end_code = ST_SUCCESS;
                           end
                        end else begin
                           phase_in = {1'b0, act_ff};
                        end
                     end else if (sync_sent_ff) begin
                        do_end   = 1'b1;
                        end_code = ST_SUCCESS;
                     end else begin
                        do_end   = 1'b1;
                        end_code = ST_CONFIG;
                     end
                  end
               end else if (req_ff.device_status != DEV_BUSY) begin
                  rsp_in.cmd_valid   = 1'b1;
                  rsp_in.cmd_kind    = act_ff - 2'd1;
                  rsp_in.cmd_address = phys_ff;
                  rsp_in.cmd_length  = chunk;
                  rsp_in.cmd_buffer_offset = (act_ff == ACT_ERASE) ? '0 : done_ff;
                  if (req_ff.device_accept) begin
                     pend_in  = chunk;
                     phase_in = PH_WAIT;
                  end else begin
                     do_end   = 1'b1;
                     end_code = ST_DRIVER;
                  end
               end
            end
         end
         default: status = ST_INVALID;
      endcase
      if (do_end) begin
         phys_in      = '0;
         rem_in       = '0;
         pend_in      = '0;
         done_in      = '0;
         sync_sent_in = 1'b0;
         act_in       = ACT_NONE;
         result_in    = end_code;
         phase_in     = stop_ff ? PH_STOPPED : PH_IDLE;
      end
      if (req_ff.opcode == OPC_TICK) begin
         status = result_in;
      end
      rsp_in.request_status = status;
      rsp_in.engine_state   = phase_in;
      rsp_in.last_result    = result_in;
      rsp_in.busy_res       = (act_in != ACT_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         act_ff       <= ACT_NONE;
         phys_ff      <= '0;
         rem_ff       <= '0;
         pend_ff      <= '0;
         done_ff      <= '0;
         sync_sent_ff <= 1'b0;
         stop_ff      <= 1'b0;
         result_ff    <= ST_SUCCESS;
      end else if (cmd.commit) begin
         phase_ff     <= phase_in;
         act_ff       <= act_in;
         phys_ff      <= phys_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         sync_sent_ff <= sync_sent_in;
         stop_ff      <= stop_in;
         result_ff    <= result_in;
      end
   end

   assign sts.req_go = is_request && (phase_ff != PH_STOPPED) && (act_ff == ACT_NONE) &&
                       zone_ok && perm_ok;
   assign sts.need_pg_div = (req_ff.opcode == OPC_TICK) && (act_ff == ACT_PROGRAM) &&
                            (phase_ff != PH_WAIT) && (req_ff.device_status == DEV_READY);
   assign sts.k_eq_z = (k_ff == req_ff.zone);
   assign sts.need_erase_div = is_erase && !range_early && !len_zero;
   assign sts.div_busy = div_busy;

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

### design/fzrs_ctrl.sv
`default_nettype none

module fzrs_ctrl
   import fzrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire fzrs_sts_type sts,
   output fzrs_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MUL,
      S_ACC,
      S_CHECK,
      S_DIV_OFF,
      S_DIV_END,
      S_DIV_PG,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.req_go) begin
               cmd.loop_init = 1'b1;
               state_in      = S_MUL;
            end else if (sts.need_pg_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_PG;
               state_in      = S_DIV_PG;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.k_eq_z ? S_CHECK : S_MUL;
         end
         S_CHECK: begin
            if (sts.need_erase_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_OFF;
               state_in      = S_DIV_OFF;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV_OFF: begin
            if (!sts.div_busy) begin
               cmd.save_off_rem = 1'b1;
               cmd.div_start    = 1'b1;
               cmd.div_sel      = DIV_END;
               state_in         = S_DIV_END;
            end
         end
         S_DIV_END: begin
            cmd.div_sel = DIV_END;
            if (!sts.div_busy) begin
               state_in = S_DONE;
            end
         end
         S_DIV_PG: begin
            cmd.div_sel = DIV_PG;
            if (!sts.div_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.div_sel = DIV_END;
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an untaken result");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result not presented after commit");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider restarted while running");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

endmodule

`default_nettype wire

### tb/sv/flash_zone_request_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module flash_zone_request_sequencer_unit_tb;
   import fzrs_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [63:0] ADDR_SPACE = 64'h1_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   flash_zone_request_sequencer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register copies
   logic [31:0] cfg_page, cfg_block, cfg_max_read;
   logic        cfg_sync;
   logic [11:0] cfg_perm;
   logic [63:0] cfg_zones;

   // engine copy
   logic [2:0]  eng_phase;
   logic [1:0]  eng_op;
   logic [31:0] eng_addr, eng_left, eng_chunk, eng_done;
   logic        eng_synced, eng_stop;
   logic [3:0]  eng_code;

   logic        cmd_v;
   logic [1:0]  cmd_k;
   logic [31:0] cmd_a, cmd_l, cmd_b;

   rsp_type pending_responses[$];
   int errors = 0;
   int cycles = 0;
   bit calm = 1'b0;
   int gap_odds = 8;
   int stall = 0;

   function automatic logic [63:0] block_bytes();
      return (cfg_block == 0) ? 64'd1 : {32'd0, cfg_block};
   endfunction

   function automatic logic [63:0] zone_bytes(int z);
      return ((cfg_zones >> (16 * z)) & 64'hFFFF) * block_bytes();
   endfunction

   function automatic void finish_op(logic [3:0] code);
      eng_addr = 0; eng_left = 0; eng_chunk = 0; eng_done = 0;
      eng_synced = 0; eng_op = ACT_NONE; eng_code = code;
      eng_phase = eng_stop ? PH_STOPPED : PH_IDLE;
   endfunction

   function automatic logic [3:0] accept_request(logic [2:0] op, int z,
                                                 logic [63:0] off, logic [63:0] len);
      logic [63:0] size, base, start, span, blk, stop_at;
      base = 0; start = off; span = len;
      if (eng_phase == PH_STOPPED) return ST_STOPPED;
      if (eng_op != ACT_NONE) return ST_BUSY;
      if (z >= ZONES_DEFAULT) return ST_INVALID;
      if (cfg_perm[3 * z + op] == 1'b0) return ST_PERMISSION;
      size = zone_bytes(z);
      if (off > size || len > size - off) return ST_RANGE;
      if (len == 0) begin
         eng_code = ST_SUCCESS;
         return ST_SUCCESS;
      end
      for (int i = 0; i < z; i++) base += zone_bytes(i);
      if (op == OPC_ERASE) begin
         blk = block_bytes();
         start = off - off % blk;
         stop_at = off + len;
         if (stop_at % blk != 0) stop_at += blk - stop_at % blk;
         if (stop_at > size) return ST_RANGE;
         span = stop_at - start;
      end
      if (base + start + span > ADDR_SPACE) return ST_RANGE;
      eng_addr = 32'(base + start);
      eng_left = 32'(span);
      eng_chunk = 0; eng_done = 0; eng_synced = 0;
      eng_op = 2'(op) + 2'd1;
      eng_phase = {1'b0, eng_op};
      eng_code = ST_IN_PROGRESS;
      return ST_IN_PROGRESS;
   endfunction

   function automatic void issue_command(logic accept);
      logic [31:0] chunk;
      logic [63:0] pg, avail;
      if (eng_op == ACT_READ) begin
         chunk = eng_left;
         if (cfg_max_read != 0 && chunk > cfg_max_read) chunk = cfg_max_read;
      end else if (eng_op == ACT_PROGRAM) begin
         pg = (cfg_page == 0) ? 64'd1 : {32'd0, cfg_page};
         avail = pg - {32'd0, eng_addr} % pg;
         chunk = ({32'd0, eng_left} < avail) ? eng_left : 32'(avail);
      end else begin
         chunk = 32'(block_bytes());
      end
      cmd_v = 1; cmd_k = eng_op - 2'd1; cmd_a = eng_addr; cmd_l = chunk;
      cmd_b = (eng_op == ACT_ERASE) ? 32'd0 : eng_done;
      if (accept) begin
         eng_chunk = chunk;
         eng_phase = PH_WAIT;
      end else begin
         finish_op(ST_DRIVER);
      end
   endfunction

   function automatic void advance_engine(logic [1:0] status, logic accept);
      if (eng_op == ACT_NONE) return;
      if (status >= 2) begin
         finish_op(ST_DRIVER);
         return;
      end
      if (eng_phase == PH_WAIT) begin
         if (status == DEV_BUSY) return;
         if (eng_chunk != 0) begin
            eng_addr = eng_addr + eng_chunk;
            eng_left = eng_left - ((eng_chunk > eng_left) ? eng_left : eng_chunk);
            if (eng_op != ACT_ERASE) eng_done = eng_done + eng_chunk;
            eng_chunk = 0;
         end else if (eng_synced) begin
            finish_op(ST_SUCCESS);
            return;
         end else begin
            finish_op(ST_CONFIG);
            return;
         end
         if (eng_left == 0) begin
            if (cfg_sync && !eng_synced) begin
               cmd_v = 1; cmd_k = KIND_SYNC;
               if (!accept) begin
                  finish_op(ST_DRIVER);
                  return;
               end
               eng_synced = 1; eng_chunk = 0; eng_phase = PH_WAIT;
            end else begin
               finish_op(ST_SUCCESS);
            end
         end else begin
            eng_phase = {1'b0, eng_op};
         end
         return;
      end
      if (status == DEV_BUSY) return;
      issue_command(accept);
   endfunction

   function automatic rsp_type next_response(req_type r);
      rsp_type o;
      logic [3:0] st;
      cmd_v = 0; cmd_k = 0; cmd_a = 0; cmd_l = 0; cmd_b = 0;
      if (r.opcode <= OPC_ERASE) begin
         st = accept_request(r.opcode, int'(r.zone), {32'd0, r.offset}, {32'd0, r.length});
      end else if (r.opcode == OPC_STOP) begin
         eng_stop = 1;
         if (eng_op == ACT_NONE) eng_phase = PH_STOPPED;
         st = ST_SUCCESS;
      end else if (r.opcode == OPC_TICK) begin
         advance_engine(r.device_status, r.device_accept);
         st = eng_code;
      end else begin
         st = ST_INVALID;
      end
      o.request_status = st;
      o.cmd_valid = cmd_v;
      o.cmd_kind = cmd_k;
      o.cmd_address = cmd_a;
      o.cmd_length = cmd_l;
      o.cmd_buffer_offset = cmd_b;
      o.engine_state = eng_phase;
      o.last_result = eng_code;
      o.busy_res = (eng_op != ACT_NONE);
      return o;
   endfunction

   task automatic flag(string msg);
      $display("%0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            flag("response with nothing outstanding");
         end else begin
            want = pending_responses.pop_front();
            compare_field("request_status", rsp_data.request_status, want.request_status);
            compare_field("cmd_valid", rsp_data.cmd_valid, want.cmd_valid);
            compare_field("cmd_kind", rsp_data.cmd_kind, want.cmd_kind);
            compare_field("cmd_address", rsp_data.cmd_address, want.cmd_address);
            compare_field("cmd_length", rsp_data.cmd_length, want.cmd_length);
            compare_field("cmd_buffer_offset", rsp_data.cmd_buffer_offset,
                          want.cmd_buffer_offset);
            compare_field("engine_state", rsp_data.engine_state, want.engine_state);
            compare_field("last_result", rsp_data.last_result, want.last_result);
            compare_field("busy_res", rsp_data.busy_res, want.busy_res);
         end
      end
   end

   always @(posedge clock) begin
      if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall <= $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_request(req_type r);
      req_data <= r;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      pending_responses.push_back(next_response(r));
      if (!calm && gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic req_type make_request(logic [2:0] op, logic [1:0] z,
                                            logic [31:0] off, logic [31:0] len);
      req_type r;
      r.opcode = op; r.zone = z; r.offset = off; r.length = len;
      r.device_status = 2'($urandom_range(0, 3));
      r.device_accept = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type make_tick(logic [1:0] status, logic accept);
      req_type r;
      r.opcode = OPC_TICK; r.zone = 2'($urandom_range(0, 3));
      r.offset = $urandom(); r.length = $urandom();
      r.device_status = status; r.device_accept = accept;
      return r;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_config(logic [16:0] page, logic [20:0] blk, logic [16:0] max_rd,
                             logic sync, logic [11:0] perm, logic [63:0] zones);
      logic [63:0] vals[6];
      drain();
      vals = '{64'(page), 64'(blk), 64'(max_rd), 64'(sync), 64'(perm), zones};
      for (int i = 0; i < 6; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      cfg_page = 32'(page); cfg_block = 32'(blk); cfg_max_read = 32'(max_rd);
      cfg_sync = sync; cfg_perm = perm; cfg_zones = zones;
   endtask

   task automatic run_ticks(int cap);
      for (int i = 0; i < cap && eng_op != ACT_NONE; i++)
         send_request(make_tick(DEV_READY, 1'b1));
   endtask

   task automatic random_tick();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 78) send_request(make_tick(DEV_READY, 1'b1));
      else if (pick < 90) send_request(make_tick(DEV_BUSY, 1'($urandom_range(0, 1))));
      else if (pick < 94) send_request(make_tick(2'($urandom_range(2, 3)),
                                                 1'($urandom_range(0, 1))));
      else send_request(make_tick(DEV_READY, 1'b0));
   endtask

   task automatic test_directed();
      set_config(17'd16, 21'd64, 17'd24, 1'b1, 12'hFFF,
                 {16'd3, 16'd2, 16'd4, 16'd3});
      for (int op = 5; op < 8; op++) send_request(make_request(3'(op), 2'd0, 0, 4));
      send_request(make_tick(DEV_READY, 1'b1));
      send_request(make_request(OPC_READ, 2'd0, 32'd0, 32'd0));
      send_request(make_request(OPC_READ, 2'd0, 32'd0, 32'd1000));
      send_request(make_request(OPC_READ, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_request(OPC_READ, 2'd1, 32'd10, 32'd60));
      send_request(make_tick(DEV_BUSY, 1'b1));
      send_request(make_request(OPC_PROGRAM, 2'd2, 32'd0, 32'd4));
      run_ticks(20);
      send_request(make_request(OPC_PROGRAM, 2'd2, 32'd10, 32'd30));
      run_ticks(20);
      send_request(make_request(OPC_ERASE, 2'd3, 32'd70, 32'd10));
      run_ticks(20);
      send_request(make_request(OPC_ERASE, 2'd3, 32'd130, 32'd62));
      send_request(make_request(OPC_READ, 2'd1, 32'd0, 32'd8));
      send_request(make_tick(DEV_READY, 1'b1));
      send_request(make_tick(2'd2, 1'b1));
      send_request(make_request(OPC_PROGRAM, 2'd1, 32'd0, 32'd8));
      send_request(make_tick(2'd3, 1'b1));
      send_request(make_request(OPC_READ, 2'd0, 32'd0, 32'd8));
      send_request(make_tick(DEV_READY, 1'b0));
   endtask

   task automatic test_permission_and_space();
      set_config(17'd0, 21'd0, 17'd0, 1'b0, 12'o5216, {16'd5, 16'd5, 16'd5, 16'd5});
      for (int z = 0; z < 4; z++)
         for (int op = 0; op < 3; op++) begin
            send_request(make_request(3'(op), 2'(z), 32'd1, 32'd2));
            run_ticks(12);
         end
      set_config(17'd65536, 21'd1048576, 17'd65536, 1'b1, 12'hFFF,
                 {16'd1, 16'd1, 16'd1, 16'hFFFF});
      send_request(make_request(OPC_READ, 2'd1, 32'd0, 32'd1));
      send_request(make_request(OPC_READ, 2'd0, 32'hFFFF_FFFF, 32'd1));
      run_ticks(6);
      send_request(make_request(OPC_ERASE, 2'd0, 32'hFFFF_FFF0, 32'd4));
      run_ticks(6);
      send_request(make_request(OPC_PROGRAM, 2'd0, 32'hFFFE_FFF0, 32'h20));
      run_ticks(8);
   endtask

   task automatic test_shrunk_block();
      set_config(17'd256, 21'd64, 17'd0, 1'b0, 12'hFFF, {16'd4, 16'd4, 16'd4, 16'd4});
      send_request(make_request(OPC_ERASE, 2'd0, 32'd0, 32'd192));
      send_request(make_tick(DEV_READY, 1'b1));
      set_config(17'd256, 21'd256, 17'd0, 1'b0, 12'hFFF, {16'd4, 16'd4, 16'd4, 16'd4});
      run_ticks(10);
   endtask

   task automatic random_phase(int count);
      int sent, cap, ticks;
      logic [2:0] op;
      logic [1:0] z;
      logic [63:0] size, off, len, unit, room;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            op = 3'($urandom_range(0, 7));
            if (op == OPC_STOP) op = OPC_TICK;
            send_request(make_request(op, 2'($urandom_range(0, 3)), $urandom(), $urandom()));
            sent++;
            continue;
         end
         op = 3'($urandom_range(0, 2));
         z = 2'($urandom_range(0, 3));
         size = zone_bytes(z);
         if (size > 64'hFFFF_FFFF) size = 64'hFFFF_FFFF;
         off = (size == 0) ? 64'd0 : {32'd0, $urandom_range(0, 32'(size - 1))};
         if (op == OPC_READ) unit = (cfg_max_read == 0) ? 64'd512 : {32'd0, cfg_max_read};
         else if (op == OPC_PROGRAM) unit = (cfg_page == 0) ? 64'd1 : {32'd0, cfg_page};
         else unit = block_bytes();
         room = size - off;
         if (room > 3 * unit) room = 3 * unit;
         len = {32'd0, $urandom_range(0, 32'(room))};
         if ($urandom_range(0, 19) == 0) len = len + 1;
         send_request(make_request(op, z, 32'(off), 32'(len)));
         sent++;
         ticks = $urandom_range(10, 40);
         for (int i = 0; i < ticks && eng_op != ACT_NONE; i++) begin
            random_tick();
            sent++;
         end
      end
   endtask

   task automatic test_random();
      gap_odds = 8;
      set_config(17'd256, 21'd4096, 17'd0, 1'b0, 12'hFFF, {16'd2, 16'd3, 16'd1, 16'd2});
      random_phase(350);
      gap_odds = 0;
      set_config(17'd1, 21'd1, 17'd1, 1'b1, 12'($urandom), {16'd40, 16'd9, 16'd0, 16'd17});
      random_phase(300);
      gap_odds = 3;
      set_config(17'd65536, 21'd1048576, 17'd65536, 1'b1, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(300);
      set_config(17'd0, 21'd0, 17'd0, 1'b0, 12'($urandom), 64'h0000_7FFF_0000_FFFF);
      random_phase(250);
      gap_odds = 6;
      set_config(17'($urandom_range(1, 300)), 21'($urandom_range(1, 500)),
                 17'($urandom_range(0, 100)), 1'($urandom_range(0, 1)), 12'hFFF,
                 {4{16'($urandom_range(1, 40))}});
      random_phase(350);
      set_config(17'd16, 21'd64, 17'd32, 1'b1, 12'hFFF, {16'd8, 16'd8, 16'd8, 16'd8});
      random_phase(300);
   endtask

   task automatic test_stop();
      calm = 1'b1;
      send_request(make_request(OPC_READ, 2'd0, 32'd0, 32'd100));
      send_request(make_tick(DEV_READY, 1'b1));
      send_request(make_request(OPC_STOP, 2'd0, 32'd0, 32'd0));
      run_ticks(20);
      for (int op = 0; op < 8; op++) send_request(make_request(3'(op), 2'd1, 32'd0, 32'd4));
      send_request(make_tick(DEV_READY, 1'b1));
      random_phase(40);
   endtask

   initial begin
      cfg_page = 256; cfg_block = 4096; cfg_max_read = 0; cfg_sync = 0;
      cfg_perm = 0; cfg_zones = 0;
      eng_stop = 0; eng_code = ST_SUCCESS;
      finish_op(ST_SUCCESS);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_permission_and_space();
      test_shrunk_block();
      test_random();
      test_stop();
      drain();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
